@@ hdl/rtcc_pkg.sv @@
`default_nettype none
package rtcc_pkg;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
	localparam logic [1:0] REG_ALARM_HOUR       = 2'd1;
	localparam logic [1:0] REG_ALARM_MINUTE     = 2'd2;
	localparam logic [1:0] REG_ALARM_SECOND     = 2'd3;

	localparam logic [7:0]  RST_TICKS_PER_SECOND = 8'd20;
	localparam logic [4:0]  RST_ALARM_HOUR       = 5'd12;
	localparam logic [5:0]  RST_ALARM_MINUTE     = 6'd56;
	localparam logic [5:0]  RST_ALARM_SECOND     = 6'd13;

	localparam logic [7:0]  RST_TICK    = 8'd0;
	localparam logic [5:0]  RST_SECOND  = 6'd49;
	localparam logic [5:0]  RST_MINUTE  = 6'd59;
	localparam logic [4:0]  RST_HOUR    = 5'd23;
	localparam logic [4:0]  RST_DAY     = 5'd14;
	localparam logic [3:0]  RST_MONTH   = 4'd5;
	localparam logic [13:0] RST_YEAR    = 14'd2008;
	localparam logic [2:0]  RST_WEEKDAY = 3'd3;

	localparam logic [5:0]  MAX_SECOND  = 6'd59;
	localparam logic [5:0]  MAX_MINUTE  = 6'd59;
	localparam logic [4:0]  MAX_HOUR    = 5'd23;
	localparam logic [3:0]  MAX_MONTH   = 4'd12;
	localparam logic [13:0] MAX_YEAR    = 14'd9999;
	localparam logic [2:0]  MAX_WEEKDAY = 3'd7;
	localparam logic [5:0]  ALARM_SEC_LIMIT = 6'd30;

	// reciprocal of 100 scaled by 2^19, exact for all 14-bit years
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	typedef struct packed {
		logic [7:0]  tick;
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [2:0]  wday;
	} clock_state_t;

	typedef struct packed {
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [2:0]  wday;
	} load_t;

	typedef struct packed {
		logic [7:0] ticks_per_second;
		logic [4:0] alarm_hour;
		logic [5:0] alarm_minute;
		logic [5:0] alarm_second;
	} cfg_t;

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] d;
		begin
			case (month)
				4'd2:    d = leap ? 5'd29 : 5'd28;
				4'd4:    d = 5'd30;
				4'd6:    d = 5'd30;
				4'd9:    d = 5'd30;
				4'd11:   d = 5'd30;
				default: d = 5'd31;
			endcase
			return d;
		end
	endfunction

endpackage
`default_nettype wire

@@ hdl/rtcc_leap.sv @@
`default_nettype none
module rtcc_leap (
	input  wire logic [13:0] year,
	output logic             leap
);
	import rtcc_pkg::*;

	logic [26:0] prod;
	logic [7:0]  cent_q;
	logic [13:0] cent_x100;
	logic        is_century;

	// year / 100 by reciprocal, then check the remainder is zero by rebuilding
	assign prod = {13'd0, year} * {14'd0, RECIP_100};
	assign cent_q = prod[RECIP_SHIFT +: 8];
	assign cent_x100 = {cent_q[7:0], 6'd0} + {1'b0, cent_q[7:0], 5'd0}
		+ {4'd0, cent_q[7:0], 2'd0};
	assign is_century = (cent_x100 == year);
	assign leap = is_century ? (cent_q[1:0] == 2'd0) : (year[1:0] == 2'd0);

endmodule
`default_nettype wire

@@ hdl/rtcc_next.sv @@
`default_nettype none
module rtcc_next (
	input  wire rtcc_pkg::clock_state_t cur,
	input  wire logic                   op,
	input  wire rtcc_pkg::load_t        ld,
	input  wire rtcc_pkg::cfg_t         cfg,
	output rtcc_pkg::clock_state_t      nxt,
	output logic                        chime,
	output logic                        alarm
);
	import rtcc_pkg::*;

	logic       leap;
	logic [8:0] tick_inc;
	logic [5:0] day_inc;
	logic [4:0] dim;

	rtcc_leap u_leap (
		.year (cur.year),
		.leap (leap)
	);

	assign tick_inc = {1'b0, cur.tick} + 9'd1;
	assign day_inc = {1'b0, cur.day} + 6'd1;
	assign dim = month_days(cur.month, leap);

	always_comb begin
		nxt = cur;
		if (op == OP_LOAD) begin
			nxt.hour = (ld.hour > MAX_HOUR) ? MAX_HOUR : ld.hour;
			nxt.min = (ld.min > MAX_MINUTE) ? MAX_MINUTE : ld.min;
			nxt.sec = (ld.sec > MAX_SECOND) ? MAX_SECOND : ld.sec;
			nxt.year = (ld.year > MAX_YEAR) ? MAX_YEAR : ld.year;
			if (ld.month == 4'd0)
				nxt.month = 4'd1;
			else if (ld.month > MAX_MONTH)
				nxt.month = MAX_MONTH;
			else
				nxt.month = ld.month;
			nxt.day = (ld.day == 5'd0) ? 5'd1 : ld.day;
			nxt.wday = (ld.wday == 3'd0) ? 3'd1 : ld.wday;
		end else if (tick_inc >= {1'b0, cfg.ticks_per_second}) begin
			nxt.tick = 8'd0;
			if (cur.sec != MAX_SECOND) begin
				nxt.sec = cur.sec + 6'd1;
			end else begin
				nxt.sec = 6'd0;
				if (cur.min != MAX_MINUTE) begin
					nxt.min = cur.min + 6'd1;
				end else begin
					nxt.min = 6'd0;
					if (cur.hour != MAX_HOUR) begin
						nxt.hour = cur.hour + 5'd1;
					end else begin
						nxt.hour = 5'd0;
						nxt.wday = (cur.wday == MAX_WEEKDAY) ? 3'd1 : cur.wday + 3'd1;
						// a loaded day past the month end also rolls over here
						if (day_inc > {1'b0, dim}) begin
							nxt.day = 5'd1;
							if (cur.month == MAX_MONTH) begin
								nxt.month = 4'd1;
								nxt.year = (cur.year == MAX_YEAR) ? 14'd0 : cur.year + 14'd1;
							end else begin
								nxt.month = cur.month + 4'd1;
							end
						end else begin
							nxt.day = day_inc[4:0];
						end
					end
				end
			end
		end else begin
			nxt.tick = tick_inc[7:0];
		end
	end

	assign chime = (nxt.min == MAX_MINUTE) && ((nxt.sec == 6'd53) || (nxt.sec == 6'd55)
		|| (nxt.sec == 6'd57) || (nxt.sec == MAX_SECOND));

	assign alarm = (nxt.hour == cfg.alarm_hour) && (nxt.min == cfg.alarm_minute)
		&& (nxt.sec == cfg.alarm_second) && !nxt.sec[0] && (nxt.sec < ALARM_SEC_LIMIT);

endmodule
`default_nettype wire

@@ hdl/calendar_clock_with_alarm_top.sv @@
// real-time clock and calendar with hourly chime and alarm compare
// input channel (in_valid/in_ready): op selects a timer tick or a load of
// time and date from the load_* fields; every request gives one result
// output channel (out_valid/out_ready): time and date after the request,
// plus chime and alarm flags computed from that new time
// the result is valid in the cycle after the request is accepted
// throughput: one request per cycle while results drain; the next state
// is computed in one pass from the clock registers, the only feedback loop
// the output register decouples the sides: a new request is taken while a
// result waits, as long as that result leaves in the same cycle; while the
// receiver stalls, in_ready drops and the held result stays unchanged
// configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 ticks per second, 1 alarm hour, 2 alarm minute, 3 alarm second)
// reset: time 23:59:49, 2008-05-14, weekday 3, tick counter 0,
// 20 ticks per second, alarm 12:56:13, no result pending
`default_nettype none
module calendar_clock_with_alarm_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [4:0]  load_hour,
	input  wire logic [5:0]  load_minute,
	input  wire logic [5:0]  load_second,
	input  wire logic [13:0] load_year,
	input  wire logic [3:0]  load_month,
	input  wire logic [4:0]  load_day,
	input  wire logic [2:0]  load_weekday,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       cur_hour,
	output logic [5:0]       cur_minute,
	output logic [5:0]       cur_second,
	output logic [13:0]      cur_year,
	output logic [3:0]       cur_month,
	output logic [4:0]       cur_day,
	output logic [2:0]       cur_weekday,
	output logic             chime,
	output logic             alarm
);
	import rtcc_pkg::*;

	cfg_t         cfg_q;
	clock_state_t state_q;
	clock_state_t state_nxt;
	load_t        ld;
	logic         chime_nxt;
	logic         alarm_nxt;
	logic         out_valid_q;
	logic         in_fire;

	assign ld = '{sec: load_second, min: load_minute, hour: load_hour, day: load_day,
		month: load_month, year: load_year, wday: load_weekday};

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire = in_valid && in_ready;

	rtcc_next u_next (
		.cur   (state_q),
		.op    (op),
		.ld    (ld),
		.cfg   (cfg_q),
		.nxt   (state_nxt),
		.chime (chime_nxt),
		.alarm (alarm_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second <= RST_TICKS_PER_SECOND;
			cfg_q.alarm_hour <= RST_ALARM_HOUR;
			cfg_q.alarm_minute <= RST_ALARM_MINUTE;
			cfg_q.alarm_second <= RST_ALARM_SECOND;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_data;
				REG_ALARM_HOUR:       cfg_q.alarm_hour <= cfg_data[4:0];
				REG_ALARM_MINUTE:     cfg_q.alarm_minute <= cfg_data[5:0];
				REG_ALARM_SECOND:     cfg_q.alarm_second <= cfg_data[5:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{tick: RST_TICK, sec: RST_SECOND, min: RST_MINUTE, hour: RST_HOUR,
				day: RST_DAY, month: RST_MONTH, year: RST_YEAR, wday: RST_WEEKDAY};
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire)
				state_q <= state_nxt;
			if (in_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded only with a request
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_hour <= state_nxt.hour;
			cur_minute <= state_nxt.min;
			cur_second <= state_nxt.sec;
			cur_year <= state_nxt.year;
			cur_month <= state_nxt.month;
			cur_day <= state_nxt.day;
			cur_weekday <= state_nxt.wday;
			chime <= chime_nxt;
			alarm <= alarm_nxt;
		end
	end

	assign out_valid = out_valid_q;

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted request did not produce a result");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (cur_second == state_q.sec) && (cur_minute == state_q.min)
			&& (cur_day == state_q.day))
		else $error("result differs from clock state");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.month != 4'd0) && (state_q.month <= MAX_MONTH)
			&& (state_q.wday != 3'd0) && (state_q.hour <= MAX_HOUR))
		else $error("clock state out of range");

	a_chime_minute: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && chime |-> (cur_minute == MAX_MINUTE) && cur_second[0])
		else $error("chime outside last minute of hour");

endmodule
`default_nettype wire

@@ verif/rtcc_checker.sv @@
`timescale 1ns / 100ps
module rtcc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        op,
	input  wire logic [4:0]  load_hour,
	input  wire logic [5:0]  load_minute,
	input  wire logic [5:0]  load_second,
	input  wire logic [13:0] load_year,
	input  wire logic [3:0]  load_month,
	input  wire logic [4:0]  load_day,
	input  wire logic [2:0]  load_weekday,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [4:0]  cur_hour,
	input  wire logic [5:0]  cur_minute,
	input  wire logic [5:0]  cur_second,
	input  wire logic [13:0] cur_year,
	input  wire logic [3:0]  cur_month,
	input  wire logic [4:0]  cur_day,
	input  wire logic [2:0]  cur_weekday,
	input  wire logic        chime,
	input  wire logic        alarm,
	output int               fail_count,
	output int               pending
);
	import rtcc_pkg::*;

	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic        chime;
		logic        alarm;
	} clock_reading_t;

	clock_reading_t readings_due[$];

	// configuration copy
	logic [7:0] ticks_cfg;
	logic [4:0] alarm_hour_cfg;
	logic [5:0] alarm_minute_cfg;
	logic [5:0] alarm_second_cfg;

	// calendar copy
	int sub_ticks;
	int sec_now, min_now, hour_now;
	int day_now, month_now, year_now, wday_now;

	function automatic int month_length(input int m, input int y);
		int n;
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			2:             n = leap ? 29 : 28;
			4, 6, 9, 11:   n = 30;
			default:       n = 31;
		endcase
		return n;
	endfunction

	function automatic int limit_to(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void next_second();
		sec_now++;
		if (sec_now < 60) return;
		sec_now = 0;
		min_now++;
		if (min_now < 60) return;
		min_now = 0;
		hour_now++;
		if (hour_now < 24) return;
		hour_now = 0;
		wday_now = (wday_now >= 7) ? 1 : wday_now + 1;
		day_now++;
		if (day_now > month_length(month_now, year_now)) begin
			day_now = 1;
			month_now++;
			if (month_now > 12) begin
				month_now = 1;
				year_now = (year_now >= 9999) ? 0 : year_now + 1;
			end
		end
	endfunction

	function automatic clock_reading_t step_calendar();
		clock_reading_t r;
		if (op == OP_LOAD) begin
			hour_now  = limit_to(int'(load_hour), 0, 23);
			min_now   = limit_to(int'(load_minute), 0, 59);
			sec_now   = limit_to(int'(load_second), 0, 59);
			year_now  = limit_to(int'(load_year), 0, 9999);
			month_now = limit_to(int'(load_month), 1, 12);
			day_now   = limit_to(int'(load_day), 1, 31);
			wday_now  = limit_to(int'(load_weekday), 1, 7);
		end else if (sub_ticks + 1 >= int'(ticks_cfg)) begin
			// a setting of zero behaves as one
			sub_ticks = 0;
			next_second();
		end else begin
			sub_ticks++;
		end
		r.hour    = 5'(hour_now);
		r.minute  = 6'(min_now);
		r.second  = 6'(sec_now);
		r.year    = 14'(year_now);
		r.month   = 4'(month_now);
		r.day     = 5'(day_now);
		r.weekday = 3'(wday_now);
		r.chime   = (min_now == 59) && (sec_now == 53 || sec_now == 55 ||
			sec_now == 57 || sec_now == 59);
		r.alarm   = (hour_now == int'(alarm_hour_cfg)) &&
			(min_now == int'(alarm_minute_cfg)) && (sec_now == int'(alarm_second_cfg)) &&
			(sec_now % 2 == 0) && (sec_now < 30);
		return r;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		clock_reading_t got;
		clock_reading_t want;
		if (!arst_n) begin
			ticks_cfg        = RST_TICKS_PER_SECOND;
			alarm_hour_cfg   = RST_ALARM_HOUR;
			alarm_minute_cfg = RST_ALARM_MINUTE;
			alarm_second_cfg = RST_ALARM_SECOND;
			sub_ticks = int'(RST_TICK);
			sec_now   = int'(RST_SECOND);
			min_now   = int'(RST_MINUTE);
			hour_now  = int'(RST_HOUR);
			day_now   = int'(RST_DAY);
			month_now = int'(RST_MONTH);
			year_now  = int'(RST_YEAR);
			wday_now  = int'(RST_WEEKDAY);
			readings_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TICKS_PER_SECOND: ticks_cfg        = cfg_data;
					REG_ALARM_HOUR:       alarm_hour_cfg   = cfg_data[4:0];
					REG_ALARM_MINUTE:     alarm_minute_cfg = cfg_data[5:0];
					REG_ALARM_SECOND:     alarm_second_cfg = cfg_data[5:0];
					default: ;
				endcase
			end
			// retire before predicting: a result always belongs to an older request
			if (out_valid && out_ready) begin
				got = '{cur_hour, cur_minute, cur_second, cur_year, cur_month, cur_day,
					cur_weekday, chime, alarm};
				if (readings_due.size() == 0) begin
					$display("%0t: result expected none got %0d:%0d:%0d %0d-%0d-%0d wd%0d",
						$time, cur_hour, cur_minute, cur_second, cur_year, cur_month,
						cur_day, cur_weekday);
					fail_count++;
				end else begin
					want = readings_due.pop_front();
					check_field("hour", int'(want.hour), int'(got.hour));
					check_field("minute", int'(want.minute), int'(got.minute));
					check_field("second", int'(want.second), int'(got.second));
					check_field("year", int'(want.year), int'(got.year));
					check_field("month", int'(want.month), int'(got.month));
					check_field("day", int'(want.day), int'(got.day));
					check_field("weekday", int'(want.weekday), int'(got.weekday));
					check_field("chime", int'(want.chime), int'(got.chime));
					check_field("alarm", int'(want.alarm), int'(got.alarm));
				end
			end
			if (in_valid && in_ready)
				readings_due.push_back(step_calendar());
		end
		pending <= readings_due.size();
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
	import rtcc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [4:0]  load_hour;
	logic [5:0]  load_minute;
	logic [5:0]  load_second;
	logic [13:0] load_year;
	logic [3:0]  load_month;
	logic [4:0]  load_day;
	logic [2:0]  load_weekday;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  cur_hour;
	logic [5:0]  cur_minute;
	logic [5:0]  cur_second;
	logic [13:0] cur_year;
	logic [3:0]  cur_month;
	logic [4:0]  cur_day;
	logic [2:0]  cur_weekday;
	logic        chime;
	logic        alarm;
	int          fail_count;
	int          pending;

	// alarm setting as last written, to aim loads at it
	logic [4:0] aim_hour;
	logic [5:0] aim_minute;
	logic [5:0] aim_second;
	bit         in_calm;

	calendar_clock_with_alarm_top dut (.*);
	rtcc_checker u_check (.*);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver: random stall before each result, with calm stretches
	initial begin : drain
		int gap;
		bit out_calm;
		out_calm = 1'b0;
		out_ready = 1'b0;
		forever begin
			if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
			gap = out_calm ? 0 : $urandom_range(0, 13);
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic push_request(input logic kind, input load_t ld);
		int gap;
		if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		op           <= kind;
		load_hour    <= ld.hour;
		load_minute  <= ld.min;
		load_second  <= ld.sec;
		load_year    <= ld.year;
		load_month   <= ld.month;
		load_day     <= ld.day;
		load_weekday <= ld.wday;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	function automatic load_t random_bits();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(load_t)-1:0];
	endfunction

	function automatic load_t random_load();
		load_t ld;
		int s;
		ld = random_bits();
		ld.month = 4'($urandom_range(1, 12));
		ld.wday  = 3'($urandom_range(1, 7));
		case ($urandom_range(0, 19))
			0, 1, 2, 3: ;  // raw bits, out-of-range values included
			4, 5, 6, 7, 8, 9, 10, 11: begin
				// just before midnight near the end of a month
				ld.hour = 5'd23;
				ld.min  = 6'd59;
				ld.sec  = 6'($urandom_range(50, 59));
				ld.day  = 5'($urandom_range(27, 31));
				case ($urandom_range(0, 5))
					0:       ld.year = 14'd9999;
					1:       ld.year = 14'd2000;
					2:       ld.year = 14'd1900;
					3:       ld.year = 14'd2024;
					default: ld.year = 14'($urandom_range(0, 9999));
				endcase
				if ($urandom_range(0, 2) == 0) ld.month = $urandom_range(0, 1) ? 4'd12 : 4'd2;
			end
			12, 13, 14, 15, 16: begin
				s = int'(aim_second) - int'($urandom_range(0, 3));
				ld.hour = aim_hour;
				ld.min  = aim_minute;
				ld.sec  = 6'((s < 0) ? 0 : s);
				ld.year = 14'($urandom_range(0, 9999));
				ld.day  = 5'($urandom_range(1, 28));
			end
			default: begin
				// top of the hour chime window
				ld.hour = 5'($urandom_range(0, 23));
				ld.min  = 6'd59;
				ld.sec  = 6'($urandom_range(50, 59));
				ld.year = 14'($urandom_range(0, 9999));
				ld.day  = 5'($urandom_range(1, 28));
			end
		endcase
		return ld;
	endfunction

	task automatic tick();
		push_request(OP_TICK, random_bits());
	endtask

	task automatic load_calendar(input int h, input int mi, input int s, input int y,
		input int mo, input int d, input int wd);
		load_t ld;
		ld.hour  = 5'(h);
		ld.min   = 6'(mi);
		ld.sec   = 6'(s);
		ld.year  = 14'(y);
		ld.month = 4'(mo);
		ld.day   = 5'(d);
		ld.wday  = 3'(wd);
		push_request(OP_LOAD, ld);
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(input logic [7:0] tps, input logic [7:0] ah,
		input logic [7:0] am, input logic [7:0] as_);
		settle();
		write_reg(REG_TICKS_PER_SECOND, tps);
		write_reg(REG_ALARM_HOUR, ah);
		write_reg(REG_ALARM_MINUTE, am);
		write_reg(REG_ALARM_SECOND, as_);
		aim_hour   = ah[4:0];
		aim_minute = am[5:0];
		aim_second = as_[5:0];
	endtask

	task automatic random_phase(input int n_items);
		repeat (n_items) begin
			if ($urandom_range(0, 7) == 0)
				push_request(OP_LOAD, random_load());
			else
				tick();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = REG_TICKS_PER_SECOND;
		cfg_data     = 8'd0;
		in_valid     = 1'b0;
		op           = OP_TICK;
		load_hour    = '0;
		load_minute  = '0;
		load_second  = '0;
		load_year    = '0;
		load_month   = '0;
		load_day     = '0;
		load_weekday = '0;
		in_calm      = 1'b0;
		aim_hour     = RST_ALARM_HOUR;
		aim_minute   = RST_ALARM_MINUTE;
		aim_second   = RST_ALARM_SECOND;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// reset settings
		random_phase(20);

		// one tick per second for the calendar corners
		configure(8'd1, 8'd12, 8'd56, 8'd14);
		tick();
		load_calendar(23, 59, 58, 9999, 12, 31, 7);
		tick();
		tick();                                   // full wrap, year to zero
		load_calendar(31, 63, 63, 16383, 15, 31, 7);  // hour, minute, second, year and month saturate
		tick();
		load_calendar(0, 0, 0, 0, 0, 0, 0);       // month, day and weekday floor at 1
		load_calendar(23, 59, 59, 2000, 2, 28, 6);
		tick();                                   // leap by the 400 rule
		load_calendar(23, 59, 59, 1900, 2, 28, 3);
		tick();                                   // century, not leap
		load_calendar(23, 59, 59, 2004, 2, 29, 7);
		tick();
		load_calendar(23, 59, 59, 2001, 2, 31, 2);
		tick();                                   // day past month length
		load_calendar(23, 59, 59, 2001, 4, 30, 4);
		tick();
		load_calendar(12, 56, 13, 2010, 6, 15, 2);
		tick();                                   // alarm hit
		load_calendar(22, 59, 52, 2010, 6, 15, 2);
		tick();                                   // chime

		// zero ticks per second acts as one
		configure(8'd0, 8'd0, 8'd0, 8'd0);
		tick();
		tick();
		// a load keeps the sub-second count
		configure(8'd3, 8'd23, 8'd59, 8'd28);
		tick();
		load_calendar(12, 0, 0, 2020, 3, 1, 1);
		tick();
		tick();

		configure(8'd1, 8'd0, 8'd0, 8'd0);
		random_phase(100);
		configure(8'd0, 8'd23, 8'd59, 8'd28);
		random_phase(60);
		configure(8'd2, 8'd12, 8'd30, 8'd14);
		random_phase(80);
		configure(8'd255, 8'd5, 8'd5, 8'd6);
		random_phase(260);
		configure(8'($urandom_range(3, 6)), 8'($urandom_range(0, 23)),
			8'($urandom_range(0, 59)), 8'(2 * $urandom_range(0, 14)));
		random_phase(50);
		// alarm registers out of range never match
		configure(8'd1, 8'hff, 8'hff, 8'hff);
		random_phase(30);
		// odd alarm second never matches either
		configure(8'd1, 8'd7, 8'd15, 8'd13);
		random_phase(20);

		settle();
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
